// ===== design/lrs_pkg.sv =====
// shared constants, action codes, command type and chain type of the load reservation station
package lrs_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int IDX_BITS_DEF   = 3;
    localparam int VALUE_BITS     = 32;
    localparam int TAG_BITS       = 5;
    localparam int OPCODE_BITS    = 8;
    localparam int ACTION_BITS    = 2;

    localparam logic [ACTION_BITS-1:0] ACT_IDLE    = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_PUSH    = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_BCAST   = 2'd2;
    localparam logic [ACTION_BITS-1:0] ACT_RELEASE = 2'd3;

    typedef struct packed {
        logic                   step;
        logic                   squash_valid;
        logic [TAG_BITS-1:0]    squash_tag;
        logic                   push_en;
        logic                   wake_en;
        logic                   release_en;
        logic [TAG_BITS-1:0]    tag;
        logic [OPCODE_BITS-1:0] opcode;
        logic [VALUE_BITS-1:0]  value_a;
        logic [TAG_BITS-1:0]    wait_a;
        logic [VALUE_BITS-1:0]  value_b;
        logic [TAG_BITS-1:0]    wait_b;
        logic [VALUE_BITS-1:0]  wake_value;
    } cmd_t;

    typedef struct packed {
        logic                   free_below;
        logic                   all_busy;
        logic                   none_busy;
        logic                   found;
        logic [TAG_BITS-1:0]    tag;
        logic [OPCODE_BITS-1:0] opcode;
        logic [VALUE_BITS-1:0]  value_a;
        logic [VALUE_BITS-1:0]  value_b;
    } chain_t;

endpackage

// ===== design/lrs_if.sv =====
// valid/ready channel interfaces for issue beats and result beats
interface lrs_in_if #(
    parameter int IDX_BITS = lrs_pkg::IDX_BITS_DEF
);
    import lrs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ACTION_BITS-1:0] action;
    logic                   squash_valid;
    logic [TAG_BITS-1:0]    squash_tag;
    logic [TAG_BITS-1:0]    tag;
    logic [OPCODE_BITS-1:0] opcode;
    logic [VALUE_BITS-1:0]  value_a;
    logic [TAG_BITS-1:0]    wait_a;
    logic [VALUE_BITS-1:0]  value_b;
    logic [TAG_BITS-1:0]    wait_b;
    logic                   addr_bcast;
    logic                   ctrl_bcast;
    logic [IDX_BITS-1:0]    slot_index;

    modport source (
        output valid, action, squash_valid, squash_tag, tag, opcode, value_a, wait_a,
               value_b, wait_b, addr_bcast, ctrl_bcast, slot_index,
        input  ready
    );

    modport sink (
        input  valid, action, squash_valid, squash_tag, tag, opcode, value_a, wait_a,
               value_b, wait_b, addr_bcast, ctrl_bcast, slot_index,
        output ready
    );
endinterface

interface lrs_out_if #(
    parameter int IDX_BITS = lrs_pkg::IDX_BITS_DEF
);
    import lrs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   ready_found;
    logic [IDX_BITS-1:0]    ready_slot;
    logic [OPCODE_BITS-1:0] ready_opcode;
    logic [VALUE_BITS-1:0]  ready_value_a;
    logic [VALUE_BITS-1:0]  ready_value_b;
    logic [TAG_BITS-1:0]    ready_tag;
    logic                   all_busy;
    logic                   none_busy;

    modport source (
        output valid, ready_found, ready_slot, ready_opcode, ready_value_a,
               ready_value_b, ready_tag, all_busy, none_busy,
        input  ready
    );

    modport sink (
        input  valid, ready_found, ready_slot, ready_opcode, ready_value_a,
               ready_value_b, ready_tag, all_busy, none_busy,
        output ready
    );
endinterface

// ===== design/lrs_cell.sv =====
// one reservation slot with its link in the push, status and oldest-ready chain
module lrs_cell #(
    parameter int IDX_BITS = lrs_pkg::IDX_BITS_DEF,
    parameter int SLOT_ID  = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lrs_pkg::cmd_t       cmd,
    input  logic [IDX_BITS-1:0] release_idx,
    input  lrs_pkg::chain_t     chain_in,
    input  logic [IDX_BITS-1:0] slot_in,
    output lrs_pkg::chain_t     chain_out,
    output logic [IDX_BITS-1:0] slot_out,
    output logic                push_here
);
    import lrs_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(SLOT_ID);

    logic                   occ_reg, occ_next;
    logic [OPCODE_BITS-1:0] opcode_reg, opcode_next;
    logic [VALUE_BITS-1:0]  value_a_reg, value_a_next;
    logic [TAG_BITS-1:0]    wait_a_reg, wait_a_next;
    logic [VALUE_BITS-1:0]  value_b_reg, value_b_next;
    logic [TAG_BITS-1:0]    wait_b_reg, wait_b_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;

    logic dying;
    logic is_ready;
    logic better;

    assign dying     = cmd.squash_valid && occ_reg && (tag_reg > cmd.squash_tag);
    assign is_ready  = occ_reg && (wait_a_reg == '0) && (wait_b_reg == '0)
                       && !(cmd.squash_valid && (tag_reg >= cmd.squash_tag));
    assign better    = is_ready && (!chain_in.found || (tag_reg < chain_in.tag));
    assign push_here = cmd.push_en && !chain_in.free_below && !occ_reg;

    always_comb
    begin
        chain_out            = chain_in;
        chain_out.free_below = chain_in.free_below || !occ_reg;
        chain_out.all_busy   = chain_in.all_busy && occ_reg;
        chain_out.none_busy  = chain_in.none_busy && !occ_reg;
        slot_out             = slot_in;
        if (better)
        begin
            chain_out.found   = 1'b1;
            chain_out.tag     = tag_reg;
            chain_out.opcode  = opcode_reg;
            chain_out.value_a = value_a_reg;
            chain_out.value_b = value_b_reg;
            slot_out          = MY_IDX;
        end
    end

    always_comb
    begin
        occ_next     = occ_reg;
        opcode_next  = opcode_reg;
        value_a_next = value_a_reg;
        wait_a_next  = wait_a_reg;
        value_b_next = value_b_reg;
        wait_b_next  = wait_b_reg;
        tag_next     = tag_reg;
        if (dying)
        begin
            occ_next    = 1'b0;
            wait_a_next = '0;
            wait_b_next = '0;
        end
        else if (push_here)
        begin
            occ_next     = 1'b1;
            opcode_next  = cmd.opcode;
            value_a_next = cmd.value_a;
            wait_a_next  = cmd.wait_a;
            value_b_next = cmd.value_b;
            wait_b_next  = cmd.wait_b;
            tag_next     = cmd.tag;
        end
        else if (cmd.wake_en && occ_reg)
        begin
            if (wait_a_reg == cmd.tag)
            begin
                value_a_next = cmd.wake_value;
                wait_a_next  = '0;
            end
            if (wait_b_reg == cmd.tag)
            begin
                value_b_next = cmd.wake_value;
                wait_b_next  = '0;
            end
        end
        else if (cmd.release_en && occ_reg && (release_idx == MY_IDX))
        begin
            occ_next    = 1'b0;
            wait_a_next = '0;
            wait_b_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= 1'b0;
            wait_a_reg <= '0;
            wait_b_reg <= '0;
        end
        else if (cmd.step)
        begin
            occ_reg    <= occ_next;
            wait_a_reg <= wait_a_next;
            wait_b_reg <= wait_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            opcode_reg  <= opcode_next;
            value_a_reg <= value_a_next;
            value_b_reg <= value_b_next;
            tag_reg     <= tag_next;
        end
    end

endmodule

// ===== design/load_reservation_station_top.sv =====
// load reservation station: row of slot cells behind one output register
// throughput: one beat per cycle while the output is not stalled; the result is valid in the cycle after the input beat
// the result comes from the slot state before that beat, found by a ripple through the cells
// a new beat is taken whenever the output register is empty or being drained
// reset clears slot occupancy, wait tags and the output valid; slot payload is not reset
module load_reservation_station_top #(
    parameter int SLOT_COUNT = lrs_pkg::SLOT_COUNT_DEF,
    parameter int IDX_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic       clk,
    input  logic       rst_n,
    lrs_in_if.sink     in_ch,
    lrs_out_if.source  out_ch
);
    import lrs_pkg::*;

    logic                   accept;
    cmd_t                   cmd;
    chain_t                 chain [SLOT_COUNT+1];
    logic [IDX_BITS-1:0]    slot  [SLOT_COUNT+1];
    logic [SLOT_COUNT-1:0]  push_vec;

    logic                   out_valid_reg;
    logic                   found_reg;
    logic [IDX_BITS-1:0]    slot_reg;
    logic [OPCODE_BITS-1:0] opcode_reg;
    logic [VALUE_BITS-1:0]  value_a_reg;
    logic [VALUE_BITS-1:0]  value_b_reg;
    logic [TAG_BITS-1:0]    tag_reg;
    logic                   all_busy_reg;
    logic                   none_busy_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        cmd.step         = accept;
        cmd.squash_valid = in_ch.squash_valid;
        cmd.squash_tag   = in_ch.squash_tag;
        cmd.push_en      = (in_ch.action == ACT_PUSH) && !in_ch.squash_valid;
        cmd.wake_en      = (in_ch.action == ACT_BCAST) && !in_ch.addr_bcast
                           && (in_ch.tag != '0);
        cmd.release_en   = (in_ch.action == ACT_RELEASE);
        cmd.tag          = in_ch.tag;
        cmd.opcode       = in_ch.opcode;
        cmd.value_a      = in_ch.value_a;
        cmd.wait_a       = in_ch.wait_a;
        cmd.value_b      = in_ch.value_b;
        cmd.wait_b       = in_ch.wait_b;
        cmd.wake_value   = in_ch.ctrl_bcast ? in_ch.value_b : in_ch.value_a;
    end

    always_comb
    begin
        chain[0]            = '0;
        chain[0].all_busy   = 1'b1;
        chain[0].none_busy  = 1'b1;
        slot[0]             = '0;
    end

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        lrs_cell #(
            .IDX_BITS (IDX_BITS),
            .SLOT_ID  (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .release_idx (in_ch.slot_index),
            .chain_in    (chain[i]),
            .slot_in     (slot[i]),
            .chain_out   (chain[i+1]),
            .slot_out    (slot[i+1]),
            .push_here   (push_vec[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg     <= chain[SLOT_COUNT].found;
            slot_reg      <= slot[SLOT_COUNT];
            opcode_reg    <= chain[SLOT_COUNT].opcode;
            value_a_reg   <= chain[SLOT_COUNT].value_a;
            value_b_reg   <= chain[SLOT_COUNT].value_b;
            tag_reg       <= chain[SLOT_COUNT].tag;
            all_busy_reg  <= chain[SLOT_COUNT].all_busy;
            none_busy_reg <= chain[SLOT_COUNT].none_busy;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.ready_found   = found_reg;
    assign out_ch.ready_slot    = slot_reg;
    assign out_ch.ready_opcode  = opcode_reg;
    assign out_ch.ready_value_a = value_a_reg;
    assign out_ch.ready_value_b = value_b_reg;
    assign out_ch.ready_tag     = tag_reg;
    assign out_ch.all_busy      = all_busy_reg;
    assign out_ch.none_busy     = none_busy_reg;

    a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(push_vec))
        else $error("push lands in more than one slot");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat left no result");

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(all_busy_reg && none_busy_reg))
        else $error("station reported both full and empty");

    a_found_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> !none_busy_reg)
        else $error("ready entry reported from an empty station");

endmodule
